// File: sv/mebe_pkg.sv
package mebe_pkg;

   // event commands
   localparam logic [2:0] CMD_HEADER      = 3'd0;
   localparam logic [2:0] CMD_TRACK_START = 3'd1;
   localparam logic [2:0] CMD_NOTE_ON     = 3'd2;
   localparam logic [2:0] CMD_NOTE_OFF    = 3'd3;
   localparam logic [2:0] CMD_PROGRAM     = 3'd4;
   localparam logic [2:0] CMD_TEMPO       = 3'd5;
   localparam logic [2:0] CMD_TIME_SIG    = 3'd6;
   localparam logic [2:0] CMD_END         = 3'd7;

   // control register indexes
   localparam int CSR_IDX_W = 2;
   localparam int CSR_W     = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_FILE_FORMAT       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TRACK_TOTAL       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TICKS_PER_QUARTER = 2'd2;

   // reset values of the control registers
   localparam logic [CSR_W-1:0] FILE_FORMAT_RST       = 16'd1;
   localparam logic [CSR_W-1:0] TRACK_TOTAL_RST       = 16'd3;
   localparam logic [CSR_W-1:0] TICKS_PER_QUARTER_RST = 16'd480;

   // byte constants of the stream
   localparam logic [7:0] CHR_M        = 8'h4D;
   localparam logic [7:0] CHR_T        = 8'h54;
   localparam logic [7:0] CHR_H        = 8'h68;
   localparam logic [7:0] CHR_D        = 8'h64;
   localparam logic [7:0] CHR_R        = 8'h72;
   localparam logic [7:0] CHR_K        = 8'h6B;
   localparam logic [7:0] HDR_LEN_BYTE = 8'h06;
   localparam logic [3:0] ST_NOTE_OFF  = 4'h8;
   localparam logic [3:0] ST_NOTE_ON   = 4'h9;
   localparam logic [3:0] ST_PROGRAM   = 4'hC;
   localparam logic [7:0] META_PREFIX  = 8'hFF;
   localparam logic [7:0] META_TEMPO   = 8'h51;
   localparam logic [7:0] META_TIMESIG = 8'h58;
   localparam logic [7:0] META_END     = 8'h2F;
   localparam logic [7:0] LEN_TEMPO    = 8'd3;
   localparam logic [7:0] LEN_TIMESIG  = 8'd4;
   localparam logic [7:0] CLOCKS_CLICK = 8'd24;
   localparam logic [7:0] N32_PER_QTR  = 8'd8;
   localparam logic [7:0] REL_VELOCITY = 8'd64;

   // one event, fully laid out as bytes
   localparam int MAX_BYTES = 14;
   localparam int IDX_W     = 4;
   localparam int DLT_BYTES = 5;

   typedef logic [IDX_W-1:0] idx_type;

   typedef struct packed {
      logic [MAX_BYTES-1:0][7:0] bytes;
      idx_type                   last_idx;
      logic                      counted;
      logic                      clear;
   } evt_type;

endpackage

// File: sv/midi_event_byte_encoder_top.sv
// MIDI event byte encoder.
// Input channel: one file event per beat (push/full). The event is laid out
// into its byte sequence at once and parked in a short event queue, so a new
// event is taken while earlier ones are still being sent.
// Result channel: one byte per beat (empty/pop), oldest first, with a flag on
// the last byte of each event and the count of track bytes so far.
// When nothing is ahead of it, the first byte of an event passes from the
// event queue into the output byte register and so onto the result ports.
// Throughput: one byte per cycle while the receiver pops, set by the single
// output byte register; an event is 3 to 14 bytes long (delta of 1 to 5 bytes
// plus its body, header 14, track start 8).
// Control registers are written through csr_write_en/csr_index/csr_wdata
// and take effect on the next event accepted; write them only while idle.
// Reset: the queue and output slot empty, the track counter goes to zero and
// the control registers return to format 1, 3 tracks, 480 ticks.
// When the receiver stalls the waiting byte holds; the event queue fills and
// full rises once QUEUE_DEPTH events are waiting.
module midi_event_byte_encoder_top #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_en,
   input  logic [mebe_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mebe_pkg::CSR_W-1:0]     csr_wdata,
   input  logic                           req_push,
   output logic                           req_full,
   input  logic [2:0]                     req_command,
   input  logic [31:0]                    req_delta_ticks,
   input  logic [3:0]                     req_channel,
   input  logic [6:0]                     req_key,
   input  logic [6:0]                     req_velocity,
   input  logic [6:0]                     req_program_req,
   input  logic [23:0]                    req_quarter_period_us,
   input  logic [7:0]                     req_beats_per_bar,
   input  logic [7:0]                     req_beat_unit,
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output logic [7:0]                     rsp_out_byte,
   output logic                           rsp_last,
   output logic [31:0]                    rsp_track_length
);
   import mebe_pkg::*;

   evt_type evt_new;
   evt_type evt_head;
   logic    head_valid;
   logic    head_pop;

   // classify and lay out the incoming event
   mebe_front u_front (
      .clock             (clock),
      .reset             (reset),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .command           (req_command),
      .delta_ticks       (req_delta_ticks),
      .channel           (req_channel),
      .key               (req_key),
      .velocity          (req_velocity),
      .program_req       (req_program_req),
      .quarter_period_us (req_quarter_period_us),
      .beats_per_bar     (req_beats_per_bar),
      .beat_unit         (req_beat_unit),
      .evt_out           (evt_new)
   );

   // event queue between front and back
   mebe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (req_push),
      .wdata    (evt_new),
      .full     (req_full),
      .pop      (head_pop),
      .rdata    (evt_head),
      .nonempty (head_valid)
   );

   // byte serializer
   mebe_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (evt_head),
      .head_valid       (head_valid),
      .head_pop         (head_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_last         (rsp_last),
      .rsp_track_length (rsp_track_length)
   );

endmodule

// File: sv/mebe_front.sv
module mebe_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_en,
   input  logic [mebe_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mebe_pkg::CSR_W-1:0]     csr_wdata,
   input  logic [2:0]                     command,
   input  logic [31:0]                    delta_ticks,
   input  logic [3:0]                     channel,
   input  logic [6:0]                     key,
   input  logic [6:0]                     velocity,
   input  logic [6:0]                     program_req,
   input  logic [23:0]                    quarter_period_us,
   input  logic [7:0]                     beats_per_bar,
   input  logic [7:0]                     beat_unit,
   output mebe_pkg::evt_type              evt_out
);
   import mebe_pkg::*;

   logic [CSR_W-1:0] file_format_ff, file_format_in;
   logic [CSR_W-1:0] track_total_ff, track_total_in;
   logic [CSR_W-1:0] ticks_ff, ticks_in;

   logic [DLT_BYTES-1:0][7:0] dlt_full;
   logic [2:0]                dlt_len;
   logic [2:0]                dlt_used;
   logic [MAX_BYTES-1:0][7:0] body;
   logic [IDX_W-1:0]          body_len;
   logic                      has_delta;
   logic [7:0]                log2_unit;

   // control registers
   always_comb begin
      file_format_in = file_format_ff;
      track_total_in = track_total_ff;
      ticks_in       = ticks_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_FILE_FORMAT:       file_format_in = csr_wdata;
            CSR_TRACK_TOTAL:       track_total_in = csr_wdata;
            CSR_TICKS_PER_QUARTER: ticks_in       = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         file_format_ff <= FILE_FORMAT_RST;
         track_total_ff <= TRACK_TOTAL_RST;
         ticks_ff       <= TICKS_PER_QUARTER_RST;
      end else begin
         file_format_ff <= file_format_in;
         track_total_ff <= track_total_in;
         ticks_ff       <= ticks_in;
      end
   end

   // variable-length delta, five-byte form and its used length
   assign dlt_full[0] = {4'h8, delta_ticks[31:28]};
   assign dlt_full[1] = {1'b1, delta_ticks[27:21]};
   assign dlt_full[2] = {1'b1, delta_ticks[20:14]};
   assign dlt_full[3] = {1'b1, delta_ticks[13:7]};
   assign dlt_full[4] = {1'b0, delta_ticks[6:0]};

   always_comb begin
      if (|delta_ticks[31:28])      dlt_len = 3'd5;
      else if (|delta_ticks[27:21]) dlt_len = 3'd4;
      else if (|delta_ticks[20:14]) dlt_len = 3'd3;
      else if (|delta_ticks[13:7])  dlt_len = 3'd2;
      else                          dlt_len = 3'd1;
   end

   // floor(log2) of the denominator, zero for 0 and 1
   always_comb begin
      log2_unit = 8'd0;
      for (int b = 1; b < 8; b++) begin
         if (beat_unit[b]) log2_unit = 8'(b);
      end
   end

   // event body after the delta
   always_comb begin
      body      = '0;
      body_len  = '0;
      has_delta = 1'b1;
      case (command)
         CMD_HEADER: begin
            body[0]  = CHR_M;
            body[1]  = CHR_T;
            body[2]  = CHR_H;
            body[3]  = CHR_D;
            body[7]  = HDR_LEN_BYTE;
            body[8]  = file_format_ff[15:8];
            body[9]  = file_format_ff[7:0];
            body[10] = track_total_ff[15:8];
            body[11] = track_total_ff[7:0];
            body[12] = ticks_ff[15:8];
            body[13] = ticks_ff[7:0];
            body_len  = 4'd14;
            has_delta = 1'b0;
         end
         CMD_TRACK_START: begin
            body[0]  = CHR_M;
            body[1]  = CHR_T;
            body[2]  = CHR_R;
            body[3]  = CHR_K;
            body_len  = 4'd8;
            has_delta = 1'b0;
         end
         CMD_NOTE_ON: begin
            body[0]  = {ST_NOTE_ON, channel};
            body[1]  = {1'b0, key};
            body[2]  = {1'b0, velocity};
            body_len = 4'd3;
         end
         CMD_NOTE_OFF: begin
            body[0]  = {ST_NOTE_OFF, channel};
            body[1]  = {1'b0, key};
            body[2]  = REL_VELOCITY;
            body_len = 4'd3;
         end
         CMD_PROGRAM: begin
            body[0]  = {ST_PROGRAM, channel};
            body[1]  = {1'b0, program_req};
            body_len = 4'd2;
         end
         CMD_TEMPO: begin
            body[0]  = META_PREFIX;
            body[1]  = META_TEMPO;
            body[2]  = LEN_TEMPO;
            body[3]  = quarter_period_us[23:16];
            body[4]  = quarter_period_us[15:8];
            body[5]  = quarter_period_us[7:0];
            body_len = 4'd6;
         end
         CMD_TIME_SIG: begin
            body[0]  = META_PREFIX;
            body[1]  = META_TIMESIG;
            body[2]  = LEN_TIMESIG;
            body[3]  = beats_per_bar;
            body[4]  = log2_unit;
            body[5]  = CLOCKS_CLICK;
            body[6]  = N32_PER_QTR;
            body_len = 4'd7;
         end
         CMD_END: begin
            body[0]  = META_PREFIX;
            body[1]  = META_END;
            body_len = 4'd3;
         end
         default: begin
            body[0]  = META_PREFIX;
            body[1]  = META_END;
            body_len = 4'd3;
         end
      endcase
   end

   // lay delta bytes ahead of the body
   assign dlt_used = has_delta ? dlt_len : 3'd0;

   always_comb begin
      for (int i = 0; i < MAX_BYTES; i++) begin
         if (i < int'(dlt_used)) begin
            evt_out.bytes[i] = dlt_full[3'(DLT_BYTES - int'(dlt_used) + i)];
         end else begin
            evt_out.bytes[i] = body[IDX_W'(i - int'(dlt_used))];
         end
      end
      evt_out.last_idx = IDX_W'({1'b0, dlt_used} + body_len - 4'd1);
      evt_out.counted  = (command != CMD_HEADER) && (command != CMD_TRACK_START);
      evt_out.clear    = (command == CMD_TRACK_START);
   end

endmodule

// File: sv/mebe_queue.sv
module mebe_queue #(
   parameter int DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  mebe_pkg::evt_type wdata,
   output logic              full,
   input  logic              pop,
   output mebe_pkg::evt_type rdata,
   output logic              nonempty
);
   import mebe_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   evt_type          mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign nonempty = (count_ff != '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && nonempty;
   assign rdata    = mem_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop)      count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= wdata;
   end

endmodule

// File: sv/mebe_back.sv
module mebe_back (
   input  logic              clock,
   input  logic              reset,
   input  mebe_pkg::evt_type head,
   input  logic              head_valid,
   output logic              head_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_last,
   output logic [31:0]       rsp_track_length
);
   import mebe_pkg::*;

   idx_type     idx_ff, idx_in;
   logic        out_valid_ff, out_valid_in;
   logic [7:0]  out_byte_ff;
   logic        out_last_ff;
   logic [31:0] out_len_ff;
   logic [31:0] count_ff, count_in;
   logic        advance, emit, at_last;

   // output slot frees when empty or when its beat is taken
   assign advance  = !out_valid_ff || rsp_pop;
   assign emit     = head_valid && advance;
   assign at_last  = (idx_ff == head.last_idx);
   assign head_pop = emit && at_last;

   // byte index within the head event, track counter
   always_comb begin
      idx_in       = idx_ff;
      count_in     = count_ff;
      out_valid_in = advance ? head_valid : out_valid_ff;
      if (emit) begin
         idx_in = at_last ? '0 : idx_ff + 1'b1;
         if (head.clear)        count_in = '0;
         else if (head.counted) count_in = count_ff + 32'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // output beat register
   always_ff @(posedge clock) begin
      if (emit) begin
         out_byte_ff <= head.bytes[idx_ff];
         out_last_ff <= at_last;
         out_len_ff  <= count_in;
      end
   end

   assign rsp_empty        = !out_valid_ff;
   assign rsp_out_byte     = out_byte_ff;
   assign rsp_last         = out_last_ff;
   assign rsp_track_length = out_len_ff;

endmodule

// File: sv/mebe_checker.sv
module mebe_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_full,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [7:0]  rsp_out_byte,
   input logic        rsp_last,
   input logic [31:0] rsp_track_length
);

   logic [31:0] prev_len_ff;

   // track length of the last beat taken
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_len_ff <= '0;
      end else if (rsp_pop && !rsp_empty) begin
         prev_len_ff <= rsp_track_length;
      end
   end

   // reset leaves both sides open and nothing to deliver
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("not idle after reset");

   // a stalled beat holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_out_byte) && $stable(rsp_last)
          && $stable(rsp_track_length)))
      else $error("stalled beat changed");

   // the counter steps by at most one per beat, or restarts at a track start
   a_len_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_pop && !rsp_empty) |->
         (rsp_track_length == prev_len_ff
          || rsp_track_length == prev_len_ff + 32'd1
          || rsp_track_length == 32'd0))
      else $error("track length jumped");

endmodule

bind midi_event_byte_encoder_top mebe_checker u_mebe_checker (
   .clock            (clock),
   .reset            (reset),
   .req_full         (req_full),
   .rsp_empty        (rsp_empty),
   .rsp_pop          (rsp_pop),
   .rsp_out_byte     (rsp_out_byte),
   .rsp_last         (rsp_last),
   .rsp_track_length (rsp_track_length)
);

// File: dv/tb_midi_event_byte_encoder_top.sv
`timescale 1ns / 1ps

module tb_midi_event_byte_encoder_top;
   import mebe_pkg::*;

   // byte values of the encoded stream
   localparam logic [31:0] TAG_MTHD        = 32'h4D546864;
   localparam logic [31:0] TAG_MTRK        = 32'h4D54726B;
   localparam logic [31:0] SMF_HDR_LEN     = 32'd6;
   localparam logic [3:0]  SMF_STATUS_OFF  = 4'h8;
   localparam logic [3:0]  SMF_STATUS_ON   = 4'h9;
   localparam logic [3:0]  SMF_STATUS_PROG = 4'hC;
   localparam logic [7:0]  SMF_META        = 8'hFF;
   localparam logic [7:0]  SMF_TEMPO       = 8'h51;
   localparam logic [7:0]  SMF_TIMESIG     = 8'h58;
   localparam logic [7:0]  SMF_EOT         = 8'h2F;
   localparam logic [7:0]  SMF_TEMPO_LEN   = 8'd3;
   localparam logic [7:0]  SMF_TIMESIG_LEN = 8'd4;
   localparam logic [7:0]  SMF_CLOCKS      = 8'd24;
   localparam logic [7:0]  SMF_N32         = 8'd8;
   localparam logic [7:0]  SMF_RELEASE     = 8'd64;

   // index with no register behind it
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 20;
   localparam int HOLD_CYCLES  = 300;

   typedef struct packed {
      logic [2:0]  command;
      logic [31:0] delta_ticks;
      logic [3:0]  channel;
      logic [6:0]  key;
      logic [6:0]  velocity;
      logic [6:0]  program_req;
      logic [23:0] quarter_period_us;
      logic [7:0]  beats_per_bar;
      logic [7:0]  beat_unit;
   } midi_event_type;

   typedef struct packed {
      logic [7:0]  data;
      logic        last;
      logic [31:0] track_length;
   } stream_byte_type;

   typedef enum {POP_ALWAYS, POP_HALF, POP_SPARSE, POP_CADENCE} pop_mode_type;

   logic        clock;
   logic        reset;
   logic        csr_write_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;
   logic        req_push;
   logic        req_full;
   logic [2:0]  req_command;
   logic [31:0] req_delta_ticks;
   logic [3:0]  req_channel;
   logic [6:0]  req_key;
   logic [6:0]  req_velocity;
   logic [6:0]  req_program_req;
   logic [23:0] req_quarter_period_us;
   logic [7:0]  req_beats_per_bar;
   logic [7:0]  req_beat_unit;
   logic        rsp_empty;
   logic        rsp_pop;
   logic [7:0]  rsp_out_byte;
   logic        rsp_last;
   logic [31:0] rsp_track_length;

   // predictor state
   logic [15:0]     hdr_format;
   logic [15:0]     hdr_tracks;
   logic [15:0]     hdr_division;
   logic [31:0]     track_count;
   logic [7:0]      event_bytes[$];
   bit              event_counted;
   stream_byte_type pending_bytes[$];

   // directed table
   midi_event_type dir_events[$];
   logic [111:0]   dir_golden[$];
   int             dir_golden_len[$];

   int mismatch_count;
   int cycle_count;
   int burst_left;
   int hold_request;

   midi_event_byte_encoder_top dut (
      .clock                 (clock),
      .reset                 (reset),
      .csr_write_en          (csr_write_en),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .req_push              (req_push),
      .req_full              (req_full),
      .req_command           (req_command),
      .req_delta_ticks       (req_delta_ticks),
      .req_channel           (req_channel),
      .req_key               (req_key),
      .req_velocity          (req_velocity),
      .req_program_req       (req_program_req),
      .req_quarter_period_us (req_quarter_period_us),
      .req_beats_per_bar     (req_beats_per_bar),
      .req_beat_unit         (req_beat_unit),
      .rsp_empty             (rsp_empty),
      .rsp_pop               (rsp_pop),
      .rsp_out_byte          (rsp_out_byte),
      .rsp_last              (rsp_last),
      .rsp_track_length      (rsp_track_length)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // run limit
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // add one byte to the event being laid out
   function automatic void put_byte(logic [7:0] b);
      event_bytes = {event_bytes, b};
   endfunction

   // append count bytes of value, most significant first
   function automatic void append_be(logic [63:0] value, int count);
      for (int i = count - 1; i >= 0; i--) put_byte(value[8*i +: 8]);
   endfunction

   // byte sequence of one event; track start clears the counter
   function automatic void lay_out_event(midi_event_type ev);
      logic [31:0] d;
      logic [7:0]  exponent;
      d = ev.delta_ticks;
      event_bytes.delete();
      event_counted = 1'b1;
      if (ev.command != CMD_HEADER && ev.command != CMD_TRACK_START) begin
         // variable-length delta, continuation bit on all but the last byte
         if (d >= 32'h10000000) put_byte({4'h8, d[31:28]});
         if (d >= 32'h00200000) put_byte({1'b1, d[27:21]});
         if (d >= 32'h00004000) put_byte({1'b1, d[20:14]});
         if (d >= 32'h00000080) put_byte({1'b1, d[13:7]});
         put_byte({1'b0, d[6:0]});
      end
      case (ev.command)
         CMD_HEADER: begin
            append_be({TAG_MTHD, SMF_HDR_LEN}, 8);
            append_be({hdr_format, hdr_tracks, hdr_division}, 6);
            event_counted = 1'b0;
         end
         CMD_TRACK_START: begin
            track_count = '0;
            append_be({TAG_MTRK, 32'd0}, 8);
            event_counted = 1'b0;
         end
         CMD_NOTE_ON: begin
            append_be({SMF_STATUS_ON, ev.channel, 1'b0, ev.key, 1'b0, ev.velocity}, 3);
         end
         CMD_NOTE_OFF: begin
            append_be({SMF_STATUS_OFF, ev.channel, 1'b0, ev.key, SMF_RELEASE}, 3);
         end
         CMD_PROGRAM: begin
            append_be({SMF_STATUS_PROG, ev.channel, 1'b0, ev.program_req}, 2);
         end
         CMD_TEMPO: begin
            append_be({SMF_META, SMF_TEMPO, SMF_TEMPO_LEN, ev.quarter_period_us}, 6);
         end
         CMD_TIME_SIG: begin
            // floor log2, 0 and 1 both give 0
            exponent = '0;
            for (int b = 1; b < 8; b++) if (ev.beat_unit[b]) exponent = 8'(b);
            append_be({SMF_META, SMF_TIMESIG, SMF_TIMESIG_LEN, ev.beats_per_bar,
                       exponent, SMF_CLOCKS, SMF_N32}, 7);
         end
         default: begin
            append_be({SMF_META, SMF_EOT, 8'd0}, 3);
         end
      endcase
   endfunction

   function automatic void queue_expected();
      stream_byte_type sb;
      for (int i = 0; i < event_bytes.size(); i++) begin
         if (event_counted) track_count = track_count + 32'd1;
         sb.data         = event_bytes[i];
         sb.last         = (i == event_bytes.size() - 1);
         sb.track_length = track_count;
         pending_bytes   = {pending_bytes, sb};
      end
   endfunction

   function automatic void add_row(logic [2:0] cmd, logic [31:0] delta, logic [3:0] chan,
                                   logic [6:0] key, logic [6:0] vel, logic [6:0] prog,
                                   logic [23:0] tempo, logic [7:0] num, logic [7:0] den,
                                   logic [111:0] golden, int golden_len);
      midi_event_type ev;
      ev = '{cmd, delta, chan, key, vel, prog, tempo, num, den};
      dir_events     = {dir_events, ev};
      dir_golden     = {dir_golden, golden};
      dir_golden_len = {dir_golden_len, golden_len};
   endfunction

   function automatic midi_event_type random_event(logic [2:0] cmd);
      midi_event_type ev;
      ev.command = cmd;
      // spread the delta over every encoded length
      case ($urandom_range(0, 5))
         0: ev.delta_ticks = $urandom_range(0, 32'h7F);
         1: ev.delta_ticks = $urandom_range(32'h80, 32'h3FFF);
         2: ev.delta_ticks = $urandom_range(32'h4000, 32'h1FFFFF);
         3: ev.delta_ticks = $urandom_range(32'h200000, 32'h0FFFFFFF);
         4: ev.delta_ticks = $urandom_range(32'h10000000, 32'hFFFFFFFF);
         default: ev.delta_ticks = $urandom();
      endcase
      ev.channel           = 4'($urandom());
      ev.key               = 7'($urandom());
      ev.velocity          = 7'($urandom());
      ev.program_req       = 7'($urandom());
      ev.quarter_period_us = 24'($urandom());
      ev.beats_per_bar     = 8'($urandom());
      case ($urandom_range(0, 3))
         0: ev.beat_unit = 8'($urandom_range(0, 1));
         1: ev.beat_unit = 8'd1 << $urandom_range(0, 7);
         default: ev.beat_unit = 8'($urandom());
      endcase
      return ev;
   endfunction

   // event inside a track; an early end now and then
   function automatic logic [2:0] pick_body_command();
      case ($urandom_range(0, 9))
         0, 1, 2: return CMD_NOTE_ON;
         3, 4, 5: return CMD_NOTE_OFF;
         6:       return CMD_PROGRAM;
         7:       return CMD_TEMPO;
         8:       return CMD_TIME_SIG;
         default: return CMD_END;
      endcase
   endfunction

   // sender: bursts with random gaps, then one beat and its prediction
   task automatic issue_event(midi_event_type ev, logic [111:0] golden, int golden_len);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_push              <= 1'b1;
      req_command           <= ev.command;
      req_delta_ticks       <= ev.delta_ticks;
      req_channel           <= ev.channel;
      req_key               <= ev.key;
      req_velocity          <= ev.velocity;
      req_program_req       <= ev.program_req;
      req_quarter_period_us <= ev.quarter_period_us;
      req_beats_per_bar     <= ev.beats_per_bar;
      req_beat_unit         <= ev.beat_unit;
      @(posedge clock);
      while (req_full) @(posedge clock);
      lay_out_event(ev);
      // typed-in bytes replace the predicted ones, the counter still runs
      if (golden_len != 0) begin
         event_bytes.delete();
         for (int i = 0; i < golden_len; i++)
            put_byte(golden[8*(golden_len-1-i) +: 8]);
      end
      queue_expected();
   endtask

   task automatic wait_drained();
      req_push <= 1'b0;
      while (pending_bytes.size() != 0) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic write_settings(logic [15:0] fmt, logic [15:0] tracks,
                                 logic [15:0] division, bit poke_spare);
      wait_drained();
      csr_write_en <= 1'b1;
      csr_index    <= CSR_FILE_FORMAT;
      csr_wdata    <= fmt;
      @(posedge clock);
      csr_index    <= CSR_TRACK_TOTAL;
      csr_wdata    <= tracks;
      @(posedge clock);
      csr_index    <= CSR_TICKS_PER_QUARTER;
      csr_wdata    <= division;
      @(posedge clock);
      // a write to the unused index must change nothing
      if (poke_spare) begin
         csr_index <= CSR_SPARE;
         csr_wdata <= 16'($urandom());
         @(posedge clock);
      end
      csr_write_en <= 1'b0;
      hdr_format   = fmt;
      hdr_tracks   = tracks;
      hdr_division = division;
   endtask

   // well-formed tracks with random content, some stray events between them
   task automatic run_tracks(int item_goal);
      int sent;
      int body;
      sent = 0;
      issue_event(random_event(CMD_HEADER), '0, 0);
      while (sent < item_goal) begin
         if ($urandom_range(0, 7) == 0) begin
            issue_event(random_event(3'($urandom_range(0, 7))), '0, 0);
            sent++;
         end else begin
            body = $urandom_range(2, 16);
            issue_event(random_event(CMD_TRACK_START), '0, 0);
            repeat (body) issue_event(random_event(pick_body_command()), '0, 0);
            issue_event(random_event(CMD_END), '0, 0);
            sent += body + 2;
         end
      end
   endtask

   // receiver: stall pattern of its own, long hold-off on request
   initial begin
      int run_left;
      int hold_left;
      pop_mode_type mode;
      rsp_pop   = 1'b0;
      run_left  = 0;
      hold_left = 0;
      mode      = POP_ALWAYS;
      forever begin
         @(posedge clock);
         if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            if (run_left == 0) begin
               mode     = pop_mode_type'($urandom_range(0, 3));
               run_left = $urandom_range(5, 60);
            end
            run_left--;
            case (mode)
               POP_ALWAYS: rsp_pop <= 1'b1;
               POP_HALF:   rsp_pop <= ($urandom_range(0, 1) == 1);
               POP_SPARSE: rsp_pop <= ($urandom_range(0, 4) == 0);
               default:    rsp_pop <= (run_left % 3 != 0);
            endcase
         end
      end
   end

   // compare each popped beat with the oldest expected byte
   always @(posedge clock) begin
      stream_byte_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_bytes.size() == 0) begin
            $error("unexpected beat: out_byte %0h last %0b track_length %0d",
                   rsp_out_byte, rsp_last, rsp_track_length);
            mismatch_count++;
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_out_byte !== want.data) begin
               $error("out_byte: expected %0h, got %0h", want.data, rsp_out_byte);
               mismatch_count++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0b, got %0b", want.last, rsp_last);
               mismatch_count++;
            end
            if (rsp_track_length !== want.track_length) begin
               $error("track_length: expected %0d, got %0d",
                      want.track_length, rsp_track_length);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      reset                 = 1'b1;
      csr_write_en          = 1'b0;
      csr_index             = CSR_FILE_FORMAT;
      csr_wdata             = '0;
      req_push              = 1'b0;
      req_command           = CMD_HEADER;
      req_delta_ticks       = '0;
      req_channel           = '0;
      req_key               = '0;
      req_velocity          = '0;
      req_program_req       = '0;
      req_quarter_period_us = '0;
      req_beats_per_bar     = '0;
      req_beat_unit         = '0;
      mismatch_count        = 0;
      burst_left            = 0;
      hold_request          = 0;
      hdr_format            = 16'd1;
      hdr_tracks            = 16'd3;
      hdr_division          = 16'd480;
      track_count           = '0;

      // cmd, delta, chan, key, vel, prog, tempo, num, den, bytes, count
      add_row(CMD_HEADER, 0, 0, 0, 0, 0, 0, 0, 0, 112'h4D546864_00000006_0001_0003_01E0, 14);
      add_row(CMD_TRACK_START, 0, 0, 0, 0, 0, 0, 0, 0, 112'h4D54726B_00000000, 8);
      add_row(CMD_NOTE_ON, 0, 0, 0, 0, 0, 0, 0, 0, 112'h00_900000, 4);
      add_row(CMD_NOTE_ON, 32'h7F, 15, 127, 127, 0, 0, 0, 0, 112'h7F_9F7F7F, 4);
      add_row(CMD_NOTE_OFF, 32'h80, 5, 60, 100, 0, 0, 0, 0, 112'h8100_853C40, 5);
      add_row(CMD_PROGRAM, 32'h3FFF, 9, 0, 0, 127, 0, 0, 0, 112'hFF7F_C97F, 4);
      add_row(CMD_PROGRAM, 32'h4000, 0, 0, 0, 0, 0, 0, 0, 112'h818000_C000, 5);
      add_row(CMD_TEMPO, 32'h1FFFFF, 0, 0, 0, 0, 24'hFFFFFF, 0, 0,
              112'hFFFF7F_FF5103_FFFFFF, 9);
      add_row(CMD_TEMPO, 32'h200000, 0, 0, 0, 0, 0, 0, 0, 112'h81808000_FF5103_000000, 10);
      add_row(CMD_TEMPO, 32'h0FFFFFFF, 0, 0, 0, 0, 24'h07A120, 0, 0,
              112'hFFFFFF7F_FF5103_07A120, 10);
      // five-byte deltas
      add_row(CMD_TIME_SIG, 32'h10000000, 0, 0, 0, 0, 0, 4, 4,
              112'h8180808000_FF5804_04021808, 12);
      add_row(CMD_TIME_SIG, 32'hFFFFFFFF, 0, 0, 0, 0, 0, 255, 255,
              112'h8FFFFFFF7F_FF5804_FF071808, 12);
      // denominators of 0 and 1 both give exponent 0
      add_row(CMD_TIME_SIG, 0, 0, 0, 0, 0, 0, 0, 0, 112'h00_FF5804_00001808, 8);
      add_row(CMD_TIME_SIG, 0, 0, 0, 0, 0, 0, 3, 1, 112'h00_FF5804_03001808, 8);
      add_row(CMD_END, 0, 0, 0, 0, 0, 0, 0, 0, 112'h00_FF2F00, 4);
      add_row(CMD_NOTE_ON, 1000, 3, 64, 90, 5, 0, 0, 0, '0, 0);
      add_row(CMD_NOTE_OFF, 20000, 10, 127, 33, 0, 0, 0, 0, '0, 0);
      add_row(CMD_TIME_SIG, 96, 0, 0, 0, 0, 0, 6, 2, '0, 0);
      add_row(CMD_TIME_SIG, 0, 0, 0, 0, 0, 0, 7, 3, '0, 0);
      add_row(CMD_TIME_SIG, 5, 0, 0, 0, 0, 0, 12, 128, '0, 0);
      add_row(CMD_TEMPO, 3000000, 0, 0, 0, 0, 24'h123456, 0, 0, '0, 0);
      // header inside a track keeps the count, a new track clears it
      add_row(CMD_HEADER, 0, 0, 0, 0, 0, 0, 0, 0, '0, 0);
      add_row(CMD_TRACK_START, 0, 0, 0, 0, 0, 0, 0, 0, '0, 0);
      add_row(CMD_END, 32'h7FFFFFFF, 0, 0, 0, 0, 0, 0, 0, '0, 0);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_events[i]) issue_event(dir_events[i], dir_golden[i], dir_golden_len[i]);

      // receiver holds off while events keep coming, so the block backs up
      wait_drained();
      hold_request = HOLD_CYCLES;
      burst_left   = 24;
      repeat (24) issue_event(random_event(pick_body_command()), '0, 0);
      wait_drained();

      run_tracks(75);
      write_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
      run_tracks(75);
      write_settings(16'h0000, 16'h0000, 16'h0000, 1'b1);
      run_tracks(75);
      write_settings(16'($urandom()), 16'($urandom()), 16'($urandom()), 1'b1);
      run_tracks(75);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_bytes.size() != 0) begin
         $error("%0d expected bytes never arrived", pending_bytes.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// File: sim.f
sv/mebe_pkg.sv
sv/mebe_front.sv
sv/mebe_queue.sv
sv/mebe_back.sv
sv/midi_event_byte_encoder_top.sv
sv/mebe_checker.sv
dv/tb_midi_event_byte_encoder_top.sv
